// ----- rtl/vou_pkg.sv -----
// ----------------------------------------------------------------------------
// vou_pkg
// Types and constants shared by the voxel occupancy update block.
// ----------------------------------------------------------------------------
package vou_pkg;

  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_HIT_INC = 2'd0;
  localparam logic [1:0] REG_CEILING = 2'd1;
  localparam logic [1:0] REG_FLOOR   = 2'd2;

  localparam logic [14:0]        HIT_INC_RST = 15'd20;
  localparam logic [14:0]        CEILING_RST = 15'd2000;
  localparam logic signed [15:0] FLOOR_RST   = -16'sd2000;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x_index;
    logic signed [15:0] y_index;
    logic signed [15:0] z_index;
    logic [15:0]        hit_intensity;
  } in_word_t;

  typedef struct packed {
    logic               in_range;
    logic signed [15:0] log_odds;
    logic [15:0]        hit_count;
    logic [15:0]        intensity_sum;
    logic [7:0]         z_low;
    logic [7:0]         z_high;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] log_odds;
    logic [15:0]        hit_count;
    logic [15:0]        intensity_sum;
    logic [7:0]         z_low;
    logic [7:0]         z_high;
  } rec_t;

  typedef struct packed {
    logic [14:0]        hit_inc;
    logic [14:0]        ceiling;
    logic signed [15:0] floor_val;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_INDEX,
    ST_READ,
    ST_MODIFY,
    ST_WRITE,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic calc_yz;
    logic calc_idx;
    logic mem_rd;
    logic modify;
    logic mem_wr;
    logic clr_wr;
    logic emit_rec;
    logic emit_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic in_range;
    logic clr_last;
  } dp_status_t;

endpackage

// ----- rtl/vou_regs.sv -----
// ----------------------------------------------------------------------------
// vou_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module vou_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vou_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output vou_pkg::cfg_t                  cfg
);
  import vou_pkg::*;

  logic [14:0]        hit_inc_r;
  logic [14:0]        ceiling_r;
  logic signed [15:0] floor_r;
  logic               wr_en;
  logic [1:0]         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_inc_r <= HIT_INC_RST;
      ceiling_r <= CEILING_RST;
      floor_r   <= FLOOR_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HIT_INC: hit_inc_r <= pwdata[14:0];
        REG_CEILING: ceiling_r <= pwdata[14:0];
        REG_FLOOR:   floor_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HIT_INC: prdata = {17'd0, hit_inc_r};
      REG_CEILING: prdata = {17'd0, ceiling_r};
      REG_FLOOR:   prdata = {{16{floor_r[15]}}, floor_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.hit_inc   = hit_inc_r;
  assign cfg.ceiling   = ceiling_r;
  assign cfg.floor_val = floor_r;

endmodule

// ----- rtl/vou_ctrl.sv -----
// ----------------------------------------------------------------------------
// vou_ctrl
// Sequencer for update, clear and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module vou_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vou_pkg::dp_status_t status,
  output vou_pkg::ctrl_cmd_t  cmd
);
  import vou_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_ADDR;
      ST_ADDR: begin
        priority if (status.op_clear) state_nxt = ST_CLEAR;
        else if (!status.in_range)    state_nxt = ST_DONE;
        else                          state_nxt = ST_INDEX;
      end
      ST_INDEX:  state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_MODIFY;
      ST_MODIFY: state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_IDLE;
      ST_CLEAR:  if (status.clr_last) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_INIT:   cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_ADDR:   cmd.calc_yz = 1'b1;
      ST_INDEX:  cmd.calc_idx = 1'b1;
      ST_READ:   cmd.mem_rd = 1'b1;
      ST_MODIFY: cmd.modify = 1'b1;
      ST_WRITE: begin
        cmd.mem_wr   = 1'b1;
        cmd.emit_rec = 1'b1;
      end
      ST_CLEAR:  cmd.clr_wr = 1'b1;
      ST_DONE:   cmd.emit_zero = 1'b1;
      default:   cmd = '0;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_write_after_modify: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> $past(cmd.modify))
    else $error("record write without preceding modify");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR && status.clr_last |=> cmd.emit_zero)
    else $error("clear sweep end did not report");

endmodule

// ----- rtl/vou_dp.sv -----
// ----------------------------------------------------------------------------
// vou_dp
// Voxel record store, index arithmetic, record update and result register.
// ----------------------------------------------------------------------------
module vou_dp #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vou_pkg::in_word_t   in_word,
  input  vou_pkg::cfg_t       cfg,
  input  vou_pkg::ctrl_cmd_t  cmd,
  output vou_pkg::dp_status_t status,
  output logic                out_valid,
  output vou_pkg::out_word_t  out_word
);
  import vou_pkg::*;

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  rec_t mem [CELLS];

  in_word_t  item_r;
  logic [AW-1:0] yz_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] clr_cnt_r;
  rec_t      rd_data_r;
  rec_t      new_rec_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  logic          x_ok, y_ok, z_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;

  logic signed [16:0] lo_sum;
  logic signed [15:0] lo_new;
  logic [15:0]        hits_new;
  logic [16:0]        isum_acc;
  logic [15:0]        isum_new;
  logic [7:0]         zu;
  logic               first_hit;
  rec_t               rec_nxt;

  // coordinate bounds
  assign x_ok = !item_r.x_index[15] && (unsigned'(item_r.x_index) < 16'(GRID_X));
  assign y_ok = !item_r.y_index[15] && (unsigned'(item_r.y_index) < 16'(GRID_Y));
  assign z_ok = !item_r.z_index[15] && (unsigned'(item_r.z_index) < 16'(GRID_Z));

  assign status.op_clear = item_r.op;
  assign status.in_range = x_ok && y_ok && z_ok;
  assign status.clr_last = (clr_cnt_r == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_word;
    end
    if (cmd.calc_yz) begin
      yz_r <= AW'(unsigned'(item_r.y_index))
            + AW'(GRID_Y) * AW'(unsigned'(item_r.z_index));
    end
    if (cmd.calc_idx) begin
      idx_r <= AW'(unsigned'(item_r.x_index)) + AW'(GRID_X) * yz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= status.clr_last ? '0 : clr_cnt_r + AW'(1);
    end
  end

  // record update
  always_comb begin
    lo_sum = {rd_data_r.log_odds[15], rd_data_r.log_odds} + $signed({2'b00, cfg.hit_inc});
    priority if (lo_sum < $signed({cfg.floor_val[15], cfg.floor_val})) begin
      lo_new = cfg.floor_val;
    end else if (lo_sum > $signed({2'b00, cfg.ceiling})) begin
      lo_new = $signed({1'b0, cfg.ceiling});
    end else begin
      lo_new = lo_sum[15:0];
    end
    hits_new  = (rd_data_r.hit_count != SAT16) ? rd_data_r.hit_count + 16'd1
                                               : rd_data_r.hit_count;
    isum_acc  = {1'b0, rd_data_r.intensity_sum} + {1'b0, item_r.hit_intensity};
    isum_new  = isum_acc[16] ? SAT16 : isum_acc[15:0];
    zu        = item_r.z_index[7:0];
    first_hit = (hits_new == 16'd1);
    rec_nxt.log_odds      = lo_new;
    rec_nxt.hit_count     = hits_new;
    rec_nxt.intensity_sum = isum_new;
    if (first_hit) begin
      rec_nxt.z_low  = zu;
      rec_nxt.z_high = zu;
    end else begin
      rec_nxt.z_low  = (zu < rd_data_r.z_low)  ? zu : rd_data_r.z_low;
      rec_nxt.z_high = (zu > rd_data_r.z_high) ? zu : rd_data_r.z_high;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      new_rec_r <= rec_nxt;
    end
  end

  // store
  assign wr_en   = cmd.mem_wr || cmd.clr_wr;
  assign wr_addr = cmd.clr_wr ? clr_cnt_r : idx_r;
  assign wr_data = cmd.clr_wr ? '0 : new_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_rec || cmd.emit_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rec) begin
      out_word_r <= {1'b1, new_rec_r};
    end else if (cmd.emit_zero) begin
      out_word_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.in_range |-> out_word_r.hit_count != 16'd0)
    else $error("in-range word with zero hit count");

  a_z_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.in_range |-> out_word_r.z_low <= out_word_r.z_high)
    else $error("z extent inverted");

  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.in_range |-> out_word_r.hit_count == 16'd0
      && out_word_r.log_odds == 16'sd0 && out_word_r.intensity_sum == 16'd0)
    else $error("out-of-range word not zero");

endmodule

// ----- rtl/voxel_occupancy_update.sv -----
// ----------------------------------------------------------------------------
// voxel_occupancy_update
// Log-odds occupancy grid of GRID_X x GRID_Y x GRID_Z voxel records.
//
// Input words are taken on start while busy is low. op 0 updates the voxel at
// (x_index, y_index, z_index); op 1 zeroes the whole grid. Each word gives
// exactly one result word, flagged by out_valid for a single cycle; the
// receiver cannot stall it.
// An in-range update steps through index multiply, index, memory read, modify
// and write with result register, and a new word is taken in the cycle the
// result appears. An out-of-range update reports a zero word without a store
// access. A clear writes one record per cycle across the whole grid. After
// reset the block sweeps the store to zero with busy high; configuration
// writes are taken throughout.
// Registers: 0x0 hit increment, 0x4 log-odds ceiling, 0x8 log-odds floor.
// ----------------------------------------------------------------------------
module voxel_occupancy_update #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  vou_pkg::in_word_t              in_word,
  output logic                           out_valid,
  output vou_pkg::out_word_t             out_word,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vou_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import vou_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  vou_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vou_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  vou_dp #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ----- sim/voxel_occupancy_update_tb.sv -----
// ----------------------------------------------------------------------------
// voxel_occupancy_update_tb
// Self-checking testbench for the voxel occupancy update block. A local model
// of the voxel grid and the three configuration registers predicts every
// result word. Directed tests cover grid corners, out-of-range coordinates,
// clamp limits, grid clears and back-to-back hits on one x/y column. Random
// traffic runs over several register settings, with random start gaps in
// all but one phase. Registers are read back and checked in several phases.
// ----------------------------------------------------------------------------
module voxel_occupancy_update_tb;
  import vou_pkg::*;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 16;
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 40;

  logic                  clk;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  in_word_t              in_word = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  rec_t      grid_model [CELLS];
  cfg_t      model_cfg = '{HIT_INC_RST, CEILING_RST, FLOOR_RST};
  out_word_t pending_results [$];
  out_word_t due;

  logic no_gaps = 1'b0;
  int   fail_count = 0;
  int   words_sent = 0;
  int   clears_sent = 0;
  int   cfg_writes = 0;
  int   results_checked = 0;

  voxel_occupancy_update #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("[voxel_occupancy_update] ERROR");
    $finish;
  end

  function automatic void clear_grid_model();
    foreach (grid_model[i]) grid_model[i] = '0;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    rec_t      c;
    int        xi, yi, zi, idx, sum, acc;
    r = '0;
    if (w.op == OP_CLEAR) begin
      clear_grid_model();
      return r;
    end
    xi = $signed(w.x_index);
    yi = $signed(w.y_index);
    zi = $signed(w.z_index);
    if (xi < 0 || xi >= GRID_X || yi < 0 || yi >= GRID_Y || zi < 0 || zi >= GRID_Z)
      return r;
    idx = xi + GRID_X * (yi + GRID_Y * zi);
    c = grid_model[idx];
    sum = $signed(c.log_odds);
    sum += int'(model_cfg.hit_inc);
    if (sum < $signed(model_cfg.floor_val)) sum = $signed(model_cfg.floor_val);
    else if (sum > int'(model_cfg.ceiling)) sum = int'(model_cfg.ceiling);
    c.log_odds = sum[15:0];
    if (c.hit_count != SAT16) c.hit_count = c.hit_count + 16'd1;
    acc = int'(c.intensity_sum) + int'(w.hit_intensity);
    c.intensity_sum = (acc > 65535) ? SAT16 : acc[15:0];
    if (c.hit_count == 16'd1) begin
      c.z_low  = w.z_index[7:0];
      c.z_high = w.z_index[7:0];
    end else begin
      if (w.z_index[7:0] < c.z_low) c.z_low = w.z_index[7:0];
      if (w.z_index[7:0] > c.z_high) c.z_high = w.z_index[7:0];
    end
    grid_model[idx] = c;
    r.in_range      = 1'b1;
    r.log_odds      = c.log_odds;
    r.hit_count     = c.hit_count;
    r.intensity_sum = c.intensity_sum;
    r.z_low         = c.z_low;
    r.z_high        = c.z_high;
    return r;
  endfunction

  function automatic in_word_t make_update(int x, int y, int z, int intensity);
    in_word_t w;
    w.op            = OP_UPDATE;
    w.x_index       = 16'(x);
    w.y_index       = 16'(y);
    w.z_index       = 16'(z);
    w.hit_intensity = 16'(intensity);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(999);
    w = make_update($urandom_range(0, GRID_X - 1), $urandom_range(0, GRID_Y - 1),
                    $urandom_range(0, GRID_Z - 1), $urandom);
    if (pick < 4) begin
      w.op      = OP_CLEAR;
      w.x_index = 16'($urandom);
      w.y_index = 16'($urandom);
      w.z_index = 16'($urandom);
    end else if (pick < 80) begin
      w.x_index = 16'($urandom);
      w.y_index = 16'($urandom);
      w.z_index = 16'($urandom);
    end else if (pick < 160) begin
      case ($urandom_range(5))
        0: w.x_index = -16'sd1;
        1: w.x_index = 16'(GRID_X);
        2: w.y_index = -16'sd1;
        3: w.y_index = 16'(GRID_Y);
        4: w.z_index = -16'sd1;
        default: w.z_index = 16'(GRID_Z);
      endcase
    end else if (pick < 600) begin
      // small hot set so voxels collect many hits
      w.x_index = 16'($urandom_range(0, 3));
      w.y_index = 16'($urandom_range(0, 1));
      w.z_index = 16'($urandom_range(0, 1));
    end
    if ($urandom_range(3) == 0) w.hit_intensity = 16'($urandom_range(60000, 65535));
    return w;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) $error("result word with no input word pending");
      end else begin
        due = pending_results.pop_front();
        check_field("in_range", due.in_range, out_word.in_range);
        check_field("log_odds", due.log_odds, out_word.log_odds);
        check_field("hit_count", due.hit_count, out_word.hit_count);
        check_field("intensity_sum", due.intensity_sum, out_word.intensity_sum);
        check_field("z_low", due.z_low, out_word.z_low);
        check_field("z_high", due.z_high, out_word.z_high);
        results_checked++;
      end
    end
  end

  task automatic send_word(in_word_t w);
    if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      repeat ($urandom_range(1, 8)) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_word(w));
    words_sent++;
    if (w.op == OP_CLEAR) clears_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_HIT_INC: model_cfg.hit_inc   = data[14:0];
      REG_CEILING: model_cfg.ceiling   = data[14:0];
      REG_FLOOR:   model_cfg.floor_val = data[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic cfg_read(logic [1:0] idx, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    cfg_read(REG_HIT_INC, rd);
    check_field("hit_increment", model_cfg.hit_inc, rd[14:0]);
    cfg_read(REG_CEILING, rd);
    check_field("log_odds_ceiling", model_cfg.ceiling, rd[14:0]);
    cfg_read(REG_FLOOR, rd);
    check_field("log_odds_floor", model_cfg.floor_val, $signed(rd[15:0]));
  endtask

  task automatic test_reset_values();
    check_regs();
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    check_regs();
  endtask

  task automatic test_corner_updates();
    send_word(make_update(0, 0, 0, 0));
    send_word(make_update(GRID_X - 1, GRID_Y - 1, GRID_Z - 1, 65535));
    send_word(make_update(GRID_X - 1, 0, 0, 1));
    send_word(make_update(0, GRID_Y - 1, GRID_Z - 1, 2));
    // intensity sum saturates
    send_word(make_update(5, 6, 7, 65535));
    send_word(make_update(5, 6, 7, 40000));
    send_word(make_update(5, 6, 7, 0));
    send_word(make_update(-1, 0, 0, 100));
    send_word(make_update(GRID_X, 0, 0, 100));
    send_word(make_update(0, -1, 0, 100));
    send_word(make_update(0, GRID_Y, 0, 100));
    send_word(make_update(0, 0, -1, 100));
    send_word(make_update(0, 0, GRID_Z, 100));
    send_word(make_update(-32768, 32767, -32768, 65535));
    send_word(make_update(32767, -32768, 32767, 65535));
    wait_idle();
  endtask

  task automatic test_clamp_settings();
    cfg_write(REG_HIT_INC, 32'h0000_7FFF);
    cfg_write(REG_CEILING, 32'h0000_7FFF);
    cfg_write(REG_FLOOR, 32'h0000_8000);
    check_regs();
    send_word(make_update(7, 9, 3, 100));
    send_word(make_update(7, 9, 3, 100));
    wait_idle();
    cfg_write(REG_CEILING, 32'h0000_0000);
    send_word(make_update(7, 9, 3, 100));
    wait_idle();
    // floor above ceiling
    cfg_write(REG_HIT_INC, 32'h0000_0000);
    cfg_write(REG_CEILING, 32'd100);
    cfg_write(REG_FLOOR, 32'd300);
    send_word(make_update(12, 20, 5, 7));
    send_word(make_update(12, 20, 5, 7));
    send_word(make_update(12, 20, 5, 7));
    wait_idle();
    cfg_write(REG_FLOOR, 32'h0000_0000);
    send_word(make_update(12, 20, 5, 7));
    wait_idle();
    // upper data bits are dropped
    cfg_write(REG_HIT_INC, 32'hDEAD_8005);
    cfg_write(REG_CEILING, 32'hFFFF_FFFF);
    cfg_write(REG_FLOOR, 32'h1234_FF00);
    check_regs();
    send_word(make_update(12, 20, 5, 7));
    wait_idle();
    cfg_write(REG_HIT_INC, {17'd0, HIT_INC_RST});
    cfg_write(REG_CEILING, {17'd0, CEILING_RST});
    cfg_write(REG_FLOOR, {16'd0, FLOOR_RST});
    check_regs();
  endtask

  task automatic test_grid_clear();
    in_word_t clr;
    clr = make_update(3, 4, 2, 500);
    clr.op = OP_CLEAR;
    send_word(make_update(3, 4, 2, 500));
    send_word(make_update(8, 1, 9, 900));
    send_word(make_update(3, 4, 2, 500));
    send_word(clr);
    send_word(make_update(3, 4, 2, 500));
    send_word(make_update(8, 1, 9, 900));
    send_word(make_update(40, 4, 2, 500));
    clr.x_index = -16'sd1;
    send_word(clr);
    send_word(clr);
    send_word(make_update(3, 4, 2, 500));
    wait_idle();
  endtask

  task automatic test_back_to_back_hits();
    no_gaps = 1'b1;
    for (int n = 0; n < 40; n++)
      send_word(make_update(GRID_X - 2, 3, $urandom_range(0, GRID_Z - 1), $urandom));
    wait_idle();
    no_gaps = 1'b0;
  endtask

  task automatic random_config();
    logic [31:0] d;
    d = $urandom;
    case ($urandom_range(3))
      0: d[14:0] = 15'd0;
      1: d[14:0] = 15'h7FFF;
      default: d[14:0] = 15'($urandom_range(1, 400));
    endcase
    cfg_write(REG_HIT_INC, d);
    d = $urandom;
    case ($urandom_range(3))
      0: d[14:0] = 15'd0;
      1: d[14:0] = 15'h7FFF;
      default: d[14:0] = 15'($urandom_range(0, 32767));
    endcase
    cfg_write(REG_CEILING, d);
    d = $urandom;
    case ($urandom_range(4))
      0: d[15:0] = 16'h8000;
      1: d[15:0] = 16'h0000;
      2: d[15:0] = 16'($urandom_range(1, 500));
      default: d[15:0] = 16'(-$urandom_range(0, 32768));
    endcase
    cfg_write(REG_FLOOR, d);
    check_regs();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) random_config();
      no_gaps = (phase == 2);
      for (int n = 0; n < 125; n++) send_word(random_word());
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clear_grid_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_corner_updates();
    test_clamp_settings();
    test_grid_clear();
    test_back_to_back_hits();
    test_random_traffic();
    $display("run covered %0d input words with %0d grid clears and %0d register writes",
             words_sent, clears_sent, cfg_writes);
    $display("%0d result words compared field by field, %0d mismatches",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("[voxel_occupancy_update] OK");
    end else begin
      $display("[voxel_occupancy_update] ERROR");
    end
    $finish;
  end

endmodule
